// File: rtl/itf_pkg.sv
// shared constants, types and colour decode for the indexed texel fetch block
// no dependencies; used by itf_ctrl, itf_datapath and the top level
package itf_pkg;

    // store sizes in bytes
    localparam int IMAGE_BYTES   = 65536;
    localparam int PALETTE_BYTES = 4096;
    localparam int IMG_AW        = $clog2(IMAGE_BYTES);
    localparam int PAL_AW        = $clog2(PALETTE_BYTES);

    // texel number y*w+x, image byte address (up to four bytes per texel),
    // palette index and palette byte address
    localparam int T_W   = 21;
    localparam int IBA_W = T_W + 3;
    localparam int IDX_W = 14;
    localparam int PBA_W = IDX_W + 3;

    // command codes
    localparam logic [1:0] CMD_WR_IMG = 2'd0;
    localparam logic [1:0] CMD_WR_PAL = 2'd1;
    localparam logic [1:0] CMD_FETCH  = 2'd2;

    // texel and palette entry formats
    localparam logic [2:0] FMT_NONE   = 3'd0;
    localparam logic [2:0] FMT_RGB16  = 3'd1;
    localparam logic [2:0] FMT_RGB24  = 3'd2;
    localparam logic [2:0] FMT_RGBA32 = 3'd3;
    localparam logic [2:0] FMT_INDEX4 = 3'd4;
    localparam logic [2:0] FMT_INDEX8 = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_TYPE    = 3'd0;
    localparam logic [2:0] CFG_PALETTE_TYPE  = 3'd1;
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_PALETTE_COUNT = 3'd4;

    localparam logic [7:0] ALPHA_TEXEL   = 8'hFF;
    localparam logic [7:0] ALPHA_PALETTE = 8'h80;

    typedef struct packed {
        logic [2:0]  image_type;
        logic [7:0]  palette_type;
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [10:0] palette_color_count;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       wr_img;
        logic       wr_pal;
        logic       mul;
        logic       iaddr;
        logic       pidx;
        logic       paddr;
        logic       rd_img;
        logic       rd_pal;
        logic [1:0] lane;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic       good;
        logic       indexed;
        logic [1:0] img_last;
        logic [1:0] pal_last;
    } dp_stat_t;

    // direct colour formats to packed rgba, r in the low byte
    function automatic logic [31:0] decode_color(logic [2:0] fmt, logic [31:0] v,
                                                 logic [7:0] alpha);
        logic [31:0] c;
        c = '0;
        case (fmt)
            FMT_RGB16:  c = {(v[15] ? alpha : 8'h00), v[14:10], 3'b000,
                             v[9:5], 3'b000, v[4:0], 3'b000};
            FMT_RGB24:  c = {8'hFF, v[23:0]};
            FMT_RGBA32: c = v;
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/indexed_texture_texel_fetch_core.sv
// Indexed texel fetch core. A write item (start with cmd 0 or 1) stores one
// byte into the image or palette store in the cycle it is taken and leaves
// busy low. A fetch item (cmd 2) holds busy high while it runs the address
// multiply and image address check, reads the texel's bytes (2, 3 or 4 for
// direct colour texels, one for 4- and 8-bit indexed texels) and, for indexed
// texels, runs the palette index and address checks and reads the palette
// entry's 2, 3 or 4 bytes. A fetch that fails the format or image address
// check, or a palette check, skips the remaining reads. Each store has a
// single byte-wide read port, which returns one byte per cycle. The colour
// appears on color with done high for exactly one cycle, in the same cycle
// that busy falls, and cannot be held off. The next item may be started in
// that same cycle. Configuration writes are always ready and must only be made
// while no fetch is in flight.
// depends on itf_pkg, itf_ctrl and itf_datapath
module indexed_texture_texel_fetch_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] byte_address,
    input  logic [7:0]  byte_value,
    input  logic [9:0]  coord_x,
    input  logic [9:0]  coord_y,
    input  logic [5:0]  palette_select,
    output logic        done,
    output logic [31:0] color,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    itf_pkg::cfg_t     cfg_reg;
    itf_pkg::dp_cmd_t  dp_cmd;
    itf_pkg::dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_type          <= itf_pkg::FMT_NONE;
            cfg_reg.palette_type        <= 8'd0;
            cfg_reg.image_width         <= 11'd1;
            cfg_reg.image_height        <= 11'd1;
            cfg_reg.palette_color_count <= 11'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                itf_pkg::CFG_IMAGE_TYPE:    cfg_reg.image_type          <= cfg_data[2:0];
                itf_pkg::CFG_PALETTE_TYPE:  cfg_reg.palette_type        <= cfg_data[7:0];
                itf_pkg::CFG_IMAGE_WIDTH:   cfg_reg.image_width         <= cfg_data;
                itf_pkg::CFG_IMAGE_HEIGHT:  cfg_reg.image_height        <= cfg_data;
                itf_pkg::CFG_PALETTE_COUNT: cfg_reg.palette_color_count <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    itf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .stat   (dp_stat),
        .dp_cmd (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    itf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .dp_cmd         (dp_cmd),
        .byte_address   (byte_address),
        .byte_value     (byte_value),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .palette_select (palette_select),
        .stat           (dp_stat),
        .color          (color)
    );

endmodule

// File: rtl/itf_ctrl.sv
// sequencer for the indexed texel fetch: accepts items, steps the datapath
// through address, image read, palette lookup and result. depends on itf_pkg
module itf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       cmd,
    input  itf_pkg::dp_stat_t stat,
    output itf_pkg::dp_cmd_t  dp_cmd,
    output logic             busy,
    output logic             done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_IADDR,
        S_ICHK,
        S_IRD,
        S_IRDW,
        S_PIDX,
        S_PADDR,
        S_PCHK,
        S_PRD,
        S_PRDW,
        S_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] k_reg;
    logic       done_reg;
    logic       accept;

    assign accept = start && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_DONE);
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg <= '0;
                    if (accept && cmd == itf_pkg::CMD_FETCH)
                        state_reg <= S_MUL;
                end
                S_MUL:   state_reg <= S_IADDR;
                S_IADDR: state_reg <= S_ICHK;
                S_ICHK:  state_reg <= stat.good ? S_IRD : S_DONE;
                S_IRD:
                begin
                    if (k_reg == stat.img_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_IRDW;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                S_IRDW:  state_reg <= stat.indexed ? S_PIDX : S_DONE;
                S_PIDX:  state_reg <= S_PADDR;
                S_PADDR: state_reg <= S_PCHK;
                S_PCHK:  state_reg <= stat.good ? S_PRD : S_DONE;
                S_PRD:
                begin
                    if (k_reg == stat.pal_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_PRDW;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                S_PRDW:  state_reg <= S_DONE;
                S_DONE:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        dp_cmd        = '0;
        dp_cmd.load   = accept && (cmd == itf_pkg::CMD_FETCH);
        dp_cmd.wr_img = accept && (cmd == itf_pkg::CMD_WR_IMG);
        dp_cmd.wr_pal = accept && (cmd == itf_pkg::CMD_WR_PAL);
        dp_cmd.mul    = (state_reg == S_MUL);
        dp_cmd.iaddr  = (state_reg == S_IADDR);
        dp_cmd.pidx   = (state_reg == S_PIDX);
        dp_cmd.paddr  = (state_reg == S_PADDR);
        dp_cmd.rd_img = (state_reg == S_IRD);
        dp_cmd.rd_pal = (state_reg == S_PRD);
        dp_cmd.lane   = k_reg;
        dp_cmd.finish = (state_reg == S_DONE);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: rtl/itf_datapath.sv
// image and palette byte stores, coordinate clamp, texel and palette
// addressing, byte gathering and colour decode. depends on itf_pkg
module itf_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  itf_pkg::cfg_t     cfg,
    input  itf_pkg::dp_cmd_t  dp_cmd,
    input  logic [15:0]       byte_address,
    input  logic [7:0]        byte_value,
    input  logic [9:0]        coord_x,
    input  logic [9:0]        coord_y,
    input  logic [5:0]        palette_select,
    output itf_pkg::dp_stat_t stat,
    output logic [31:0]       color
);

    logic [7:0] image_mem [itf_pkg::IMAGE_BYTES];
    logic [7:0] pal_mem   [itf_pkg::PALETTE_BYTES];

    logic [9:0]                  x_cl_reg;
    logic [9:0]                  y_cl_reg;
    logic [5:0]                  sel_reg;
    logic [itf_pkg::T_W-1:0]     t_reg;
    logic [itf_pkg::IBA_W-1:0]   iaddr_reg;
    logic [itf_pkg::IDX_W-1:0]   pidx_reg;
    logic [itf_pkg::PBA_W-1:0]   paddr_reg;
    logic [31:0]                 value_reg;
    logic [7:0]                  img_q_reg;
    logic [7:0]                  pal_q_reg;
    logic [1:0]                  cap_lane_reg;
    logic                        cap_img_reg;
    logic                        cap_pal_reg;
    logic                        good_reg;
    logic [31:0]                 color_reg;

    logic [10:0]                 w_eff;
    logic [10:0]                 h_eff;
    logic [10:0]                 w_max;
    logic [10:0]                 h_max;
    logic [9:0]                  x_cl;
    logic [9:0]                  y_cl;
    logic [itf_pkg::T_W-1:0]     t_next;
    logic [itf_pkg::IBA_W-1:0]   iaddr_next;
    logic [2:0]                  img_n;
    logic                        img_fmt_ok;
    logic                        iaddr_ok;
    logic                        indexed;
    logic [3:0]                  nib;
    logic [itf_pkg::IDX_W-1:0]   idx_raw;
    logic [itf_pkg::IDX_W-1:0]   pidx_next;
    logic                        idx_ok;
    logic [2:0]                  pal_fmt;
    logic                        pal_fmt_ok;
    logic [itf_pkg::PBA_W-1:0]   paddr_next;
    logic [2:0]                  pal_n;
    logic                        paddr_ok;
    logic [itf_pkg::IMG_AW-1:0]  img_rd_addr;
    logic [itf_pkg::PAL_AW-1:0]  pal_rd_addr;
    logic                        img_wr_ok;
    logic                        pal_wr_ok;
    logic [31:0]                 color_next;

    // zero width or height behaves as one
    assign w_eff = (cfg.image_width == 11'd0) ? 11'd1 : cfg.image_width;
    assign h_eff = (cfg.image_height == 11'd0) ? 11'd1 : cfg.image_height;
    assign w_max = w_eff - 11'd1;
    assign h_max = h_eff - 11'd1;
    assign x_cl  = ({1'b0, coord_x} > w_max) ? w_max[9:0] : coord_x;
    assign y_cl  = ({1'b0, coord_y} > h_max) ? h_max[9:0] : coord_y;

    assign t_next = itf_pkg::T_W'(y_cl_reg) * itf_pkg::T_W'(w_eff)
                  + itf_pkg::T_W'(x_cl_reg);

    assign indexed = (cfg.image_type == itf_pkg::FMT_INDEX4)
                  || (cfg.image_type == itf_pkg::FMT_INDEX8);

    always_comb
    begin
        iaddr_next = itf_pkg::IBA_W'(t_reg);
        img_n      = 3'd1;
        img_fmt_ok = 1'b1;
        unique case (cfg.image_type)
            itf_pkg::FMT_RGB16:
            begin
                iaddr_next = itf_pkg::IBA_W'({t_reg, 1'b0});
                img_n      = 3'd2;
            end
            itf_pkg::FMT_RGB24:
            begin
                iaddr_next = itf_pkg::IBA_W'({t_reg, 1'b0}) + itf_pkg::IBA_W'(t_reg);
                img_n      = 3'd3;
            end
            itf_pkg::FMT_RGBA32:
            begin
                iaddr_next = itf_pkg::IBA_W'({t_reg, 2'b00});
                img_n      = 3'd4;
            end
            // two texels per byte
            itf_pkg::FMT_INDEX4: iaddr_next = itf_pkg::IBA_W'(t_reg[itf_pkg::T_W-1:1]);
            itf_pkg::FMT_INDEX8: iaddr_next = itf_pkg::IBA_W'(t_reg);
            default:             img_fmt_ok = 1'b0;
        endcase
    end

    assign iaddr_ok = img_fmt_ok
        && (({1'b0, iaddr_next} + (itf_pkg::IBA_W + 1)'(img_n))
            <= (itf_pkg::IBA_W + 1)'(itf_pkg::IMAGE_BYTES));

    // palette index; for 8-bit indexed texels the csm1 layout swaps bits 3 and 4 of the index
    assign nib     = t_reg[0] ? value_reg[7:4] : value_reg[3:0];
    assign idx_raw = (cfg.image_type == itf_pkg::FMT_INDEX4)
                   ? itf_pkg::IDX_W'({sel_reg, nib})
                   : itf_pkg::IDX_W'({sel_reg, value_reg[7:0]});
    assign idx_ok  = indexed && (idx_raw < itf_pkg::IDX_W'(cfg.palette_color_count));
    assign pidx_next = ((cfg.image_type == itf_pkg::FMT_INDEX8) && !cfg.palette_type[7])
                     ? {idx_raw[itf_pkg::IDX_W-1:5], idx_raw[3], idx_raw[4], idx_raw[2:0]}
                     : idx_raw;

    assign pal_fmt_ok = (cfg.palette_type[5:0] == 6'(itf_pkg::FMT_RGB16))
                     || (cfg.palette_type[5:0] == 6'(itf_pkg::FMT_RGB24))
                     || (cfg.palette_type[5:0] == 6'(itf_pkg::FMT_RGBA32));
    assign pal_fmt = pal_fmt_ok ? cfg.palette_type[2:0] : itf_pkg::FMT_NONE;

    always_comb
    begin
        paddr_next = itf_pkg::PBA_W'({pidx_reg, 1'b0});
        pal_n      = 3'd2;
        unique case (pal_fmt)
            itf_pkg::FMT_RGB24:
            begin
                paddr_next = itf_pkg::PBA_W'({pidx_reg, 1'b0}) + itf_pkg::PBA_W'(pidx_reg);
                pal_n      = 3'd3;
            end
            itf_pkg::FMT_RGBA32:
            begin
                paddr_next = itf_pkg::PBA_W'({pidx_reg, 2'b00});
                pal_n      = 3'd4;
            end
            default:
            begin
                paddr_next = itf_pkg::PBA_W'({pidx_reg, 1'b0});
                pal_n      = 3'd2;
            end
        endcase
    end

    assign paddr_ok = pal_fmt_ok
        && (({1'b0, paddr_next} + (itf_pkg::PBA_W + 1)'(pal_n))
            <= (itf_pkg::PBA_W + 1)'(itf_pkg::PALETTE_BYTES));

    // byte stores, one read port each, registered read data
    assign img_wr_ok   = dp_cmd.wr_img && (32'(byte_address) < itf_pkg::IMAGE_BYTES);
    assign pal_wr_ok   = dp_cmd.wr_pal && (32'(byte_address) < itf_pkg::PALETTE_BYTES);
    assign img_rd_addr = iaddr_reg[itf_pkg::IMG_AW-1:0] + itf_pkg::IMG_AW'(dp_cmd.lane);
    assign pal_rd_addr = paddr_reg[itf_pkg::PAL_AW-1:0] + itf_pkg::PAL_AW'(dp_cmd.lane);

    always_ff @(posedge clk)
    begin
        if (img_wr_ok)
            image_mem[byte_address[itf_pkg::IMG_AW-1:0]] <= byte_value;
        img_q_reg <= image_mem[img_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr_ok)
            pal_mem[byte_address[itf_pkg::PAL_AW-1:0]] <= byte_value;
        pal_q_reg <= pal_mem[pal_rd_addr];
    end

    always_comb
    begin
        if (!good_reg)
            color_next = '0;
        else if (indexed)
            color_next = itf_pkg::decode_color(pal_fmt, value_reg, itf_pkg::ALPHA_PALETTE);
        else
            color_next = itf_pkg::decode_color(cfg.image_type, value_reg,
                                               itf_pkg::ALPHA_TEXEL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_img_reg <= 1'b0;
            cap_pal_reg <= 1'b0;
            good_reg    <= 1'b0;
        end
        else
        begin
            cap_img_reg <= dp_cmd.rd_img;
            cap_pal_reg <= dp_cmd.rd_pal;
            priority if (dp_cmd.load)
                good_reg <= 1'b1;
            else if (dp_cmd.iaddr)
                good_reg <= good_reg && iaddr_ok;
            else if (dp_cmd.pidx)
                good_reg <= good_reg && idx_ok;
            else if (dp_cmd.paddr)
                good_reg <= good_reg && paddr_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_lane_reg <= dp_cmd.lane;
        if (dp_cmd.load)
        begin
            x_cl_reg <= x_cl;
            y_cl_reg <= y_cl;
            sel_reg  <= palette_select;
        end
        if (dp_cmd.mul)
            t_reg <= t_next;
        if (dp_cmd.iaddr)
            iaddr_reg <= iaddr_next;
        if (dp_cmd.pidx)
            pidx_reg <= pidx_next;
        if (dp_cmd.paddr)
            paddr_reg <= paddr_next;
        // little-endian gather, one byte lane per read beat
        priority if (dp_cmd.iaddr || dp_cmd.paddr)
            value_reg <= '0;
        else if (cap_img_reg)
            value_reg[cap_lane_reg*8 +: 8] <= img_q_reg;
        else if (cap_pal_reg)
            value_reg[cap_lane_reg*8 +: 8] <= pal_q_reg;
        if (dp_cmd.finish)
            color_reg <= color_next;
    end

    assign stat.good     = good_reg;
    assign stat.indexed  = indexed;
    assign stat.img_last = 2'(img_n - 3'd1);
    assign stat.pal_last = 2'(pal_n - 3'd1);
    assign color         = color_reg;

endmodule

// File: tb/sv/tb_indexed_texture_texel_fetch_core.sv
// self-checking bench for indexed_texture_texel_fetch_core: a directed table and
// randomised write/fetch traffic, scored against a behavioural texel decoder
// depends on itf_pkg and the indexed_texture_texel_fetch_core rtl
module tb_indexed_texture_texel_fetch_core;
    import itf_pkg::*;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [2:0]  FMT_RSVD     = 3'd6;
    localparam logic [7:0]  PAL_CSM2     = 8'h80;
    localparam int unsigned RAND_ITEMS   = 1100;
    localparam int unsigned PHASE_ITEMS  = 40;
    localparam int unsigned SETTLE       = 20;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned PRINT_LIMIT  = 50;

    typedef enum logic [1:0] {ROW_ITEM, ROW_FIXED, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [5:0]  sel;
        logic [2:0]  reg_idx;
        logic [10:0] reg_data;
        logic [31:0] want;
    } row_t;

    // byte run in one of the stores, n zero when nothing is read
    typedef struct packed {
        logic        ok;
        logic [2:0]  n;
        logic [31:0] addr;
        logic [31:0] t;
    } span_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = CMD_WR_IMG;
    logic [15:0] byte_address = '0;
    logic [7:0]  byte_value = '0;
    logic [9:0]  coord_x = '0;
    logic [9:0]  coord_y = '0;
    logic [5:0]  palette_select = '0;
    logic        done;
    logic [31:0] color;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    // shadow of the block's registers and stores
    logic [2:0]  m_type = FMT_NONE;
    logic [7:0]  m_pal_type = '0;
    logic [10:0] m_width = 11'd1;
    logic [10:0] m_height = 11'd1;
    logic [10:0] m_count = '0;
    logic [7:0]  img_mem [IMAGE_BYTES];
    bit          img_seen [IMAGE_BYTES];
    logic [7:0]  lut_mem [PALETTE_BYTES];
    bit          lut_seen [PALETTE_BYTES];

    logic [31:0] colour_q [$];
    row_t        plan [$];
    logic [31:0] head;
    int unsigned errors = 0;
    int unsigned taken = 0;
    int unsigned gap_pct = 0;
    int unsigned quiet_cycles = 0;

    indexed_texture_texel_fetch_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .byte_address   (byte_address),
        .byte_value     (byte_value),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .palette_select (palette_select),
        .done           (done),
        .color          (color),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic span_t texel_span(logic [9:0] x, logic [9:0] y);
        span_t       s;
        int unsigned w;
        int unsigned h;
        int unsigned cx;
        int unsigned cy;
        w  = (m_width == 0) ? 1 : m_width;
        h  = (m_height == 0) ? 1 : m_height;
        cx = (x > w - 1) ? w - 1 : x;
        cy = (y > h - 1) ? h - 1 : y;
        s = '0;
        s.t = cy * w + cx;
        case (m_type)
            FMT_RGB16:              s.n = 3'd2;
            FMT_RGB24:              s.n = 3'd3;
            FMT_RGBA32:             s.n = 3'd4;
            FMT_INDEX4, FMT_INDEX8: s.n = 3'd1;
            default:                s.n = 3'd0;
        endcase
        // two texels share a byte in 4-bit indexed data
        s.addr = (m_type == FMT_INDEX4) ? s.t >> 1 : s.t * s.n;
        s.ok = (s.n != 0) && (s.addr + s.n <= IMAGE_BYTES);
        return s;
    endfunction

    function automatic span_t lut_span(logic [9:0] x, logic [9:0] y, logic [5:0] sel);
        span_t       s;
        span_t       ts;
        logic [7:0]  b;
        int unsigned i;
        s = '0;
        ts = texel_span(x, y);
        if (!ts.ok || m_count == 0 || (m_type != FMT_INDEX4 && m_type != FMT_INDEX8))
            return s;
        b = img_mem[ts.addr];
        if (m_type == FMT_INDEX4)
            i = sel * 16 + (ts.t[0] ? b[7:4] : b[3:0]);
        else
            i = sel * 256 + b;
        if (i >= m_count)
            return s;
        // csm1 stores colours 8-15 and 16-23 of each group of 32 swapped
        if (m_type == FMT_INDEX8 && !m_pal_type[7])
        begin
            if (i % 32 >= 8 && i % 32 < 16)
                i = i + 8;
            else if (i % 32 >= 16 && i % 32 < 24)
                i = i - 8;
        end
        case (m_pal_type[5:0])
            FMT_RGB16:  s.n = 3'd2;
            FMT_RGB24:  s.n = 3'd3;
            FMT_RGBA32: s.n = 3'd4;
            default:    s.n = 3'd0;
        endcase
        s.addr = i * s.n;
        s.ok = (s.n != 0) && (s.addr + s.n <= PALETTE_BYTES);
        return s;
    endfunction

    function automatic logic [31:0] store_word(bit lut, logic [31:0] addr, logic [2:0] n);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < n; k++)
            v[8*k +: 8] = lut ? lut_mem[addr + k] : img_mem[addr + k];
        return v;
    endfunction

    // byte count selects the colour layout: 2 is 1-5-5-5, 3 is rgb, 4 is rgba
    function automatic logic [31:0] rgba_from(logic [2:0] n, logic [31:0] v,
                                              logic [7:0] alpha);
        case (n)
            3'd2:    return {(v[15] ? alpha : 8'h00), v[14:10], 3'b000,
                             v[9:5], 3'b000, v[4:0], 3'b000};
            3'd3:    return {8'hFF, v[23:0]};
            default: return v;
        endcase
    endfunction

    function automatic logic [31:0] predict_colour(logic [9:0] x, logic [9:0] y,
                                                   logic [5:0] sel);
        span_t ts;
        span_t ls;
        ts = texel_span(x, y);
        if (!ts.ok)
            return 32'h0;
        if (m_type == FMT_INDEX4 || m_type == FMT_INDEX8)
        begin
            ls = lut_span(x, y, sel);
            return ls.ok ? rgba_from(ls.n, store_word(1'b1, ls.addr, ls.n), ALPHA_PALETTE)
                         : 32'h0;
        end
        return rgba_from(ts.n, store_word(1'b0, ts.addr, ts.n), ALPHA_TEXEL);
    endfunction

    function automatic logic [9:0] pick_coord(int unsigned extent);
        int unsigned top;
        top = (extent > 1024) ? 1023 : extent - 1;
        case ($urandom_range(3))
            0:       return 10'($urandom_range(1023));
            1:       return $urandom_range(1) ? 10'(top) : 10'd0;
            default: return 10'($urandom_range(top));
        endcase
    endfunction

    function automatic logic [10:0] pick_dim();
        case ($urandom_range(9))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1024;
            3:       return 11'd2047;
            default: return 11'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic void row_item(logic [1:0] op, logic [15:0] addr, logic [7:0] value,
                                     logic [9:0] x, logic [9:0] y, logic [5:0] sel);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.op = op;
        r.addr = addr;
        r.value = value;
        r.x = x;
        r.y = y;
        r.sel = sel;
        plan.push_back(r);
    endfunction

    function automatic void row_fixed(logic [9:0] x, logic [9:0] y, logic [5:0] sel,
                                      logic [31:0] want);
        row_t r;
        r = '0;
        r.kind = ROW_FIXED;
        r.op = CMD_FETCH;
        r.x = x;
        r.y = y;
        r.sel = sel;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic void row_reg(logic [2:0] idx, logic [10:0] data);
        row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_data = data;
        plan.push_back(r);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("mismatch at %0t: %s got %08h want %08h", $time, what, got, want);
        errors++;
    endtask

    // one command beat; the shadow is updated at the edge that takes it
    task automatic issue(input logic [1:0] op, input logic [15:0] addr,
                         input logic [7:0] value, input logic [9:0] x, input logic [9:0] y,
                         input logic [5:0] sel, input bit fixed, input logic [31:0] want);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start          <= 1'b1;
        cmd            <= op;
        byte_address   <= addr;
        byte_value     <= value;
        coord_x        <= x;
        coord_y        <= y;
        palette_select <= sel;
        do
            @(posedge clk);
        while (busy);
        case (op)
            CMD_WR_IMG:
            begin
                if (addr < IMAGE_BYTES)
                begin
                    img_mem[addr] = value;
                    img_seen[addr] = 1'b1;
                    taken++;
                end
            end
            CMD_WR_PAL:
            begin
                if (addr < PALETTE_BYTES)
                begin
                    lut_mem[addr] = value;
                    lut_seen[addr] = 1'b1;
                    taken++;
                end
            end
            CMD_FETCH:
            begin
                colour_q.push_back(fixed ? want : predict_colour(x, y, sel));
                taken++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [10:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_IMAGE_TYPE:    m_type = data[2:0];
            CFG_PALETTE_TYPE:  m_pal_type = data[7:0];
            CFG_IMAGE_WIDTH:   m_width = data;
            CFG_IMAGE_HEIGHT:  m_height = data;
            CFG_PALETTE_COUNT: m_count = data;
            default:           m_count = m_count;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hold off until every colour is back, then let the block settle
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (colour_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (colour_q.size() == 0)
                flag_mismatch("colour with nothing pending", color, 32'h0);
            else
            begin
                head = colour_q.pop_front();
                if (color !== head)
                    flag_mismatch("colour", color, head);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("indexed_texture_texel_fetch_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        span_t       ts;
        span_t       ls;
        logic [9:0]  fx;
        logic [9:0]  fy;
        logic [5:0]  fs;
        logic [10:0] cnt;
        int unsigned base;
        int unsigned span;
        int unsigned phase;
        int unsigned roll;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        row_fixed(10'h3FF, 10'h3FF, 6'h3F, 32'h0);    // no format after reset
        row_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF, 6'h3F);
        row_item(CMD_WR_IMG, 16'hFFFF, 8'hFF, 10'h0, 10'h0, 6'h0);
        row_item(CMD_WR_PAL, 16'hFFFF, 8'hAA, 10'h0, 10'h0, 6'h0);
        row_item(CMD_WR_IMG, 16'h0000, 8'hFF, 10'h0, 10'h0, 6'h0);
        row_item(CMD_WR_IMG, 16'h0001, 8'hFF, 10'h0, 10'h0, 6'h0);
        row_reg(CFG_IMAGE_TYPE, FMT_RGB16);
        row_fixed(10'h0, 10'h0, 6'h0, 32'hFFF8F8F8);
        row_fixed(10'h3FF, 10'h3FF, 6'h3F, 32'hFFF8F8F8);
        row_reg(CFG_IMAGE_WIDTH, 11'd0);
        row_reg(CFG_IMAGE_HEIGHT, 11'd0);
        row_fixed(10'd9, 10'd3, 6'h0, 32'hFFF8F8F8);
        row_reg(CFG_IMAGE_WIDTH, 11'd1024);
        row_reg(CFG_IMAGE_HEIGHT, 11'd1024);
        row_fixed(10'h3FF, 10'h3FF, 6'h0, 32'h0);     // texel past the image store
        row_item(CMD_WR_IMG, 16'h0002, 8'h12, 10'h0, 10'h0, 6'h0);
        row_item(CMD_WR_IMG, 16'h0003, 8'h80, 10'h0, 10'h0, 6'h0);
        row_reg(CFG_IMAGE_TYPE, FMT_RGBA32);
        row_item(CMD_FETCH, 16'h0, 8'h0, 10'h0, 10'h0, 6'h0);
        row_reg(CFG_IMAGE_TYPE, FMT_RGB24);
        row_item(CMD_FETCH, 16'h0, 8'h0, 10'h0, 10'h0, 6'h0);
        row_reg(CFG_IMAGE_TYPE, FMT_RSVD);
        row_fixed(10'h0, 10'h0, 6'h0, 32'h0);
        row_item(CMD_WR_IMG, 16'h0004, 8'h08, 10'h0, 10'h0, 6'h0);
        row_reg(CFG_IMAGE_TYPE, FMT_INDEX8);
        row_fixed(10'd4, 10'h0, 6'h0, 32'h0);         // empty palette
        row_reg(CFG_PALETTE_COUNT, 11'd1024);
        row_fixed(10'd4, 10'h0, 6'h0, 32'h0);         // palette format none
        row_item(CMD_WR_PAL, 16'd48, 8'h11, 10'h0, 10'h0, 6'h0);
        row_item(CMD_WR_PAL, 16'd49, 8'h22, 10'h0, 10'h0, 6'h0);
        row_item(CMD_WR_PAL, 16'd50, 8'h33, 10'h0, 10'h0, 6'h0);
        row_reg(CFG_PALETTE_TYPE, FMT_RGB24);
        row_item(CMD_FETCH, 16'h0, 8'h0, 10'd4, 10'h0, 6'h0);
        row_reg(CFG_PALETTE_COUNT, 11'd8);
        row_fixed(10'd4, 10'h0, 6'h0, 32'h0);         // index equal to the count
        row_reg(CFG_PALETTE_COUNT, 11'd2047);
        row_reg(CFG_PALETTE_TYPE, PAL_CSM2 | FMT_RGBA32);
        row_fixed(10'd4, 10'h0, 6'd4, 32'h0);         // entry past the palette store
        row_reg(CFG_IMAGE_TYPE, FMT_INDEX4);
        row_reg(CFG_PALETTE_TYPE, FMT_RGB16);
        row_item(CMD_WR_PAL, 16'd4, 8'hFF, 10'h0, 10'h0, 6'h0);
        row_item(CMD_WR_PAL, 16'd5, 8'hFF, 10'h0, 10'h0, 6'h0);
        row_item(CMD_FETCH, 16'h0, 8'h0, 10'd4, 10'h0, 6'h0);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_REG)
            begin
                drain();
                write_reg(plan[r].reg_idx, plan[r].reg_data);
            end
            else
                issue(plan[r].op, plan[r].addr, plan[r].value, plan[r].x, plan[r].y,
                      plan[r].sel, plan[r].kind == ROW_FIXED, plan[r].want);
        end

        base = taken;
        phase = 0;
        while (taken - base < RAND_ITEMS)
        begin
            drain();
            write_reg(CFG_IMAGE_TYPE, ($urandom_range(3) == 0) ? 11'($urandom_range(7))
                      : 11'($urandom_range(FMT_RGB16, FMT_INDEX8)));
            write_reg(CFG_PALETTE_TYPE, {3'b000, 1'($urandom_range(1)),
                      1'($urandom_range(1)), (($urandom_range(4) == 0)
                      ? 6'($urandom_range(63)) : 6'($urandom_range(FMT_RGB16, FMT_RGBA32)))});
            write_reg(CFG_IMAGE_WIDTH, pick_dim());
            write_reg(CFG_IMAGE_HEIGHT, pick_dim());
            case ($urandom_range(7))
                0:       cnt = 11'd0;
                1:       cnt = 11'd2047;
                2:       cnt = 11'd1024;
                3:       cnt = 11'd16;
                4:       cnt = 11'd256;
                default: cnt = 11'($urandom_range(1, 2047));
            endcase
            write_reg(CFG_PALETTE_COUNT, cnt);
            case (phase % 4)
                1:       gap_pct = 77;
                3:       gap_pct = 12;
                default: gap_pct = 0;
            endcase

            repeat (PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                begin
                    // fill whatever the fetch will read, then fetch
                    fx = pick_coord((m_width == 0) ? 1 : m_width);
                    fy = pick_coord((m_height == 0) ? 1 : m_height);
                    span = (m_type == FMT_INDEX8) ? m_count / 256 : m_count / 16;
                    fs = ($urandom_range(3) == 0 || span > 63) ? 6'($urandom_range(63))
                         : 6'($urandom_range(span));
                    ts = texel_span(fx, fy);
                    if (ts.ok)
                        for (int k = 0; k < ts.n; k++)
                            if (!img_seen[ts.addr + k])
                                issue(CMD_WR_IMG, 16'(ts.addr + k), 8'($urandom),
                                      10'($urandom), 10'($urandom), 6'($urandom), 1'b0, '0);
                    ls = lut_span(fx, fy, fs);
                    if (ls.ok)
                        for (int k = 0; k < ls.n; k++)
                            if (!lut_seen[ls.addr + k])
                                issue(CMD_WR_PAL, 16'(ls.addr + k), 8'($urandom),
                                      10'($urandom), 10'($urandom), 6'($urandom), 1'b0, '0);
                    issue(CMD_FETCH, 16'($urandom), 8'($urandom), fx, fy, fs, 1'b0, '0);
                end
                else if (roll < 85)
                    issue(CMD_WR_IMG, 16'($urandom), 8'($urandom), 10'($urandom),
                          10'($urandom), 6'($urandom), 1'b0, '0);
                else if (roll < 95)
                    issue(CMD_WR_PAL, ($urandom_range(4) == 0) ? 16'($urandom)
                          : 16'($urandom_range(PALETTE_BYTES - 1)), 8'($urandom),
                          10'($urandom), 10'($urandom), 6'($urandom), 1'b0, '0);
                else
                    issue(CMD_UNUSED, 16'($urandom), 8'($urandom), 10'($urandom),
                          10'($urandom), 6'($urandom), 1'b0, '0);
            end
            phase++;
        end

        drain();
        if (errors == 0)
            $display("indexed_texture_texel_fetch_core verification clean");
        else
            $display("indexed_texture_texel_fetch_core verification failed");
        $finish;
    end

endmodule
